// File: rtl/lpft_pkg.sv
// Shared constants, types and controller encodings for the LRU page frame tracker.
`default_nettype none
package lpft_pkg;

  localparam int FRAMES      = 8;
  localparam int PAGE_BITS   = 16;
  localparam int FRAME_IDX_W = $clog2(FRAMES);
  localparam int COUNT_W     = $clog2(FRAMES + 1);
  localparam int CFG_W       = 4;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;

  localparam logic [CFG_W-1:0] FRAMES_IN_USE_RESET = CFG_W'(8);

  // Register index, taken from paddr[2].
  localparam logic REG_FRAMES_IN_USE = 1'b0;

  typedef logic [PAGE_BITS-1:0]   page_t;
  typedef logic [FRAME_IDX_W-1:0] frame_idx_t;
  typedef logic [COUNT_W-1:0]     count_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_UPDATE
  } lpft_state_t;

  typedef struct packed {
    logic load;    // capture the referenced page
    logic match;   // register the compare vector
    logic commit;  // update the list and load the result register
  } lpft_cmd_t;

endpackage
`default_nettype wire

// File: rtl/lpft_ctrl.sv
// Controller state machine and result valid flag for the LRU page frame tracker.
`default_nettype none
module lpft_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  wire               out_ready,
  output lpft_pkg::lpft_cmd_t cmd_o
);
  import lpft_pkg::*;

  lpft_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_o.load = 1'b1;
          state_nxt  = ST_MATCH;
        end
      end
      ST_MATCH: begin
        cmd_o.match = 1'b1;
        state_nxt   = ST_UPDATE;
      end
      ST_UPDATE: begin
        // The result register must be free, or emptied in this cycle.
        if (!out_valid_r || out_ready) begin
          cmd_o.commit = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  a_rise_from_update: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_UPDATE)
    else $error("result appeared outside the update step");

  a_match_then_update: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MATCH |=> state_r == ST_UPDATE)
    else $error("match step not followed by update");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPDATE && out_valid_r && !out_ready) |=> state_r == ST_UPDATE)
    else $error("update left while the result register was still full");

endmodule
`default_nettype wire

// File: rtl/lpft_datapath.sv
// Resident page list, parallel compare, shift and append, and result registers.
`default_nettype none
module lpft_datapath (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire lpft_pkg::lpft_cmd_t    cmd_i,
  input  wire lpft_pkg::page_t        page_i,
  input  wire [lpft_pkg::CFG_W-1:0]   frames_in_use_i,
  output logic                        hit_o,
  output lpft_pkg::frame_idx_t        hit_position_o,
  output logic                        evicted_valid_o,
  output lpft_pkg::page_t             evicted_page_o,
  output lpft_pkg::count_t            resident_count_o
);
  import lpft_pkg::*;

  page_t      pages_r [FRAMES];
  page_t      pages_nxt [FRAMES];
  page_t      up_w [FRAMES];
  count_t     fill_r, fill_nxt;
  page_t      page_r;
  logic [FRAMES-1:0] match_r;

  logic       hit_r, evicted_valid_r;
  frame_idx_t hit_position_r;
  page_t      evicted_page_r;

  logic       hit_w, evict_w, drop_w;
  frame_idx_t pos_w, dpos_w;
  count_t     lim_w, fill_drop_w;

  // Each entry's neighbor one place toward the most-recent end.
  for (genvar g = 0; g < FRAMES; g++) begin : g_up
    if (g < FRAMES - 1) begin : g_next
      assign up_w[g] = pages_r[g+1];
    end else begin : g_last
      assign up_w[g] = pages_r[g];
    end
  end

  always_comb begin
    if (frames_in_use_i == '0) begin
      lim_w = count_t'(1);
    end else if (COUNT_W'(frames_in_use_i) > count_t'(FRAMES)) begin
      lim_w = count_t'(FRAMES);
    end else begin
      lim_w = COUNT_W'(frames_in_use_i);
    end
  end

  // Lowest matching position wins.
  always_comb begin
    pos_w = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        pos_w = frame_idx_t'(i);
      end
    end
  end

  assign hit_w       = |match_r;
  assign evict_w     = !hit_w && (fill_r >= lim_w) && (fill_r != '0);
  assign drop_w      = hit_w || evict_w;
  assign dpos_w      = hit_w ? pos_w : '0;
  assign fill_drop_w = fill_r - count_t'(drop_w);
  assign fill_nxt    = (fill_drop_w < count_t'(FRAMES)) ? fill_drop_w + count_t'(1)
                                                        : fill_drop_w;

  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      if (count_t'(i) == fill_drop_w) begin
        pages_nxt[i] = page_r;
      end else if (drop_w && frame_idx_t'(i) >= dpos_w && count_t'(i) < fill_drop_w) begin
        pages_nxt[i] = up_w[i];
      end else begin
        pages_nxt[i] = pages_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cmd_i.commit) begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      page_r <= page_i;
    end
    if (cmd_i.match) begin
      for (int i = 0; i < FRAMES; i++) begin
        match_r[i] <= (pages_r[i] == page_r) && (count_t'(i) < fill_r);
      end
    end
    if (cmd_i.commit) begin
      for (int i = 0; i < FRAMES; i++) begin
        pages_r[i] <= pages_nxt[i];
      end
      hit_r           <= hit_w;
      hit_position_r  <= hit_w ? pos_w : '0;
      evicted_valid_r <= evict_w;
      evicted_page_r  <= evict_w ? pages_r[0] : '0;
    end
  end

  assign hit_o            = hit_r;
  assign hit_position_o   = hit_position_r;
  assign evicted_valid_o  = evicted_valid_r;
  assign evicted_page_o   = evicted_page_r;
  assign resident_count_o = fill_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= count_t'(FRAMES))
    else $error("fill count beyond frame count");

  a_hit_keeps_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_i.commit && hit_w) |=> fill_r == $past(fill_r))
    else $error("hit changed the fill count");

  a_evict_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_i.commit && evict_w) |=> evicted_valid_o && fill_r == $past(fill_r))
    else $error("eviction not reported or fill count moved");

endmodule
`default_nettype wire

// File: rtl/lru_page_frame_tracker_core.sv
// Top level of the LRU page frame tracker: register port, controller and datapath.
//
// Usage: each input beat on in_valid/in_ready carries one page reference
// (in_page_number). The block keeps up to eight resident pages ordered from
// least to most recently used, and for every reference returns exactly one
// output beat on out_valid/out_ready with hit, hit_position, evicted_valid,
// evicted_page and resident_count.
// Each reference passes in turn through capture, a registered eight-way
// compare, then the shift-and-append update, which a small controller
// sequences; a new reference is taken only after the previous update.
// The result register parts the two sides, so a new reference is taken
// while the previous result still waits. When the receiver stalls, the
// update step holds until the result register empties; in_ready stays low
// until then.
// Reset (rst_n, synchronous, active low) empties the list and sets
// frames_in_use to 8. The register sits at byte address 0 of the APB-style
// port and should be written only while the block is idle.
`default_nettype none
module lru_page_frame_tracker_core (
  input  wire                          clk,
  input  wire                          rst_n,
  // Configuration port.
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [lpft_pkg::ADDR_W-1:0]   paddr,
  input  wire [lpft_pkg::DATA_W-1:0]   pwdata,
  output logic [lpft_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  // Reference input channel.
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire [lpft_pkg::PAGE_BITS-1:0] in_page_number,
  // Result channel.
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic                         out_hit,
  output logic [lpft_pkg::FRAME_IDX_W-1:0] out_hit_position,
  output logic                         out_evicted_valid,
  output logic [lpft_pkg::PAGE_BITS-1:0] out_evicted_page,
  output logic [lpft_pkg::COUNT_W-1:0] out_resident_count
);
  import lpft_pkg::*;

  logic [CFG_W-1:0] frames_in_use_r;
  logic             cfg_write_w;
  lpft_cmd_t        cmd_w;

  // The port never inserts wait states. Byte address bit 2 selects the
  // register; an address with bit 2 set is ignored on write and reads back
  // as zero.
  assign pready      = 1'b1;
  assign cfg_write_w = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_in_use_r <= FRAMES_IN_USE_RESET;
    end else if (cfg_write_w && paddr[2] == REG_FRAMES_IN_USE) begin
      frames_in_use_r <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_FRAMES_IN_USE) begin
      prdata = DATA_W'(frames_in_use_r);
    end
  end

  // The controller walks each reference through capture, compare and update.
  lpft_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd_o     (cmd_w)
  );

  // The datapath holds the ordered list and the result register payload.
  lpft_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_i            (cmd_w),
    .page_i           (in_page_number),
    .frames_in_use_i  (frames_in_use_r),
    .hit_o            (out_hit),
    .hit_position_o   (out_hit_position),
    .evicted_valid_o  (out_evicted_valid),
    .evicted_page_o   (out_evicted_page),
    .resident_count_o (out_resident_count)
  );

endmodule
`default_nettype wire

// File: sim/lru_page_frame_tracker_core_test.sv
// Self-checking testbench for the LRU page frame tracker core with its own LRU list predictor.
module lru_page_frame_tracker_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lpft_pkg::*;

  // Each side idles in about this many cycles out of a hundred by default.
  localparam int IDLE_PCT        = 22;
  // Cycles without any accepted beat before the run is declared hung. The
  // longest legal quiet stretch is little more than the receiver hold-off
  // below, so this leaves a wide margin.
  localparam int STALL_LIMIT     = 4000;
  // Length of the deliberate receiver hold-off that backs the block up.
  localparam int HOLDOFF_CYCLES  = 250;
  // Cycles to let pass after the last result before changing the register.
  localparam int SETTLE_CYCLES   = 4;
  localparam int RANDOM_PHASES   = 6;
  localparam int REFS_PER_PHASE  = 108;
  localparam int HOT_PAGES       = 10;
  // Position value used while a search has not found the page yet.
  localparam int NOT_FOUND       = -1;

  // The register index sits in paddr[2]; index 1 has no register behind it.
  localparam logic [ADDR_W-1:0] ADDR_FRAMES_IN_USE = {REG_FRAMES_IN_USE, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_SPARE_REG     = {~REG_FRAMES_IN_USE, 2'b00};

  // One expected result beat, at the widths of the result ports.
  typedef struct packed {
    logic       hit;
    frame_idx_t hit_position;
    logic       evicted_valid;
    page_t      evicted_page;
    count_t     resident_count;
  } lookup_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_W-1:0]    paddr;
  logic [DATA_W-1:0]    pwdata;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;
  logic                 in_valid;
  logic                 in_ready;
  page_t                in_page_number;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_hit;
  frame_idx_t           out_hit_position;
  logic                 out_evicted_valid;
  page_t                out_evicted_page;
  count_t               out_resident_count;

  // Predictor state: the resident list from least to most recently used, and
  // the frame limit register as last written.
  page_t              resident_list[$];
  logic [CFG_W-1:0]   frames_in_use;
  // Results predicted for accepted references, oldest first.
  lookup_result_t     pending_results[$];
  // Working set that the random phases draw most references from.
  page_t              hot_pages[HOT_PAGES];

  int error_count     = 0;
  int quiet_cycles    = 0;
  int idle_pct        = IDLE_PCT;
  int holdoffs_asked  = 0;
  int holdoffs_served = 0;
  int holdoff_left    = 0;

  lru_page_frame_tracker_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_page_number    (in_page_number),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_hit           (out_hit),
    .out_hit_position  (out_hit_position),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_resident_count(out_resident_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // A limit of zero behaves as one frame, anything above the frame count as
  // the full frame count.
  function automatic int frame_limit();
    if (frames_in_use == 0) return 1;
    if (frames_in_use > FRAMES) return FRAMES;
    return frames_in_use;
  endfunction

  // Applies one reference to the predicted list and returns the result beat
  // the block must produce for it.
  function automatic lookup_result_t predict_lookup(page_t page);
    lookup_result_t r;
    int pos;
    r = '0;
    pos = NOT_FOUND;
    // The lowest matching position wins, should a page ever appear twice.
    foreach (resident_list[i]) begin
      if (pos == NOT_FOUND && resident_list[i] == page) pos = i;
    end
    if (pos != NOT_FOUND) begin
      // A hit only moves the page to the most recent end; nothing leaves.
      r.hit = 1'b1;
      r.hit_position = frame_idx_t'(pos);
      resident_list.delete(pos);
    end else if (resident_list.size() >= frame_limit() && resident_list.size() > 0) begin
      // A fault on a list at or over the limit evicts exactly one page, even
      // when the limit was lowered below the current fill.
      r.evicted_valid = 1'b1;
      r.evicted_page = resident_list.pop_front();
    end
    if (resident_list.size() < FRAMES) resident_list.insert(resident_list.size(), page);
    r.resident_count = count_t'(resident_list.size());
    return r;
  endfunction

  function automatic void compare_field(string name, logic [DATA_W-1:0] want,
                                        logic [DATA_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endfunction

  // Offers one reference beat, possibly after a random gap, and records its
  // predicted result once the block takes it. in_valid is left high on
  // return so that back-to-back beats never drop it for a cycle.
  task automatic send_reference(input page_t page);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_page_number <= page;
    do @(posedge clk); while (!in_ready);
    pending_results.insert(pending_results.size(), predict_lookup(page));
  endtask

  // Stops offering beats and waits until every predicted result has been
  // seen, then lets the pipeline settle before anything else happens.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes a register, then reads the frame limit straight back in a
  // back-to-back transfer. Only ever called with the block idle.
  task automatic program_register(input logic [ADDR_W-1:0] addr,
                                  input logic [CFG_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    // Upper data bits are noise that the register must drop.
    pwdata <= ($urandom() << CFG_W) | DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr[2] == REG_FRAMES_IN_USE) frames_in_use = value;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_FRAMES_IN_USE;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    compare_field("prdata", DATA_W'(frames_in_use), prdata);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Limit zero must behave as a single frame: every fault swaps the page.
  task automatic test_limit_zero();
    program_register(ADDR_FRAMES_IN_USE, 4'd0);
    send_reference(16'h0000);
    send_reference(16'hFFFF);
    send_reference(16'hFFFF);
    send_reference(16'h5555);
    wait_drained();
  endtask

  // An out-of-range limit must clamp to the full frame count; the list fills
  // to eight, hits at both ends and in the middle move pages, then a fault
  // evicts the oldest page.
  task automatic test_limit_wide();
    program_register(ADDR_FRAMES_IN_USE, 4'd15);
    send_reference(16'hAAAA);
    send_reference(16'h0001);
    send_reference(16'h8000);
    send_reference(16'h1234);
    send_reference(16'hFEDC);
    send_reference(16'h7FFF);
    send_reference(16'h0002);
    send_reference(16'h5555);
    send_reference(16'h5555);
    send_reference(16'hAAAA);
    send_reference(16'h8000);
    send_reference(16'h4321);
    wait_drained();
  endtask

  // With the limit dropped below the fill, a fault still evicts one page and
  // the count holds at eight; a hit evicts nothing.
  task automatic test_limit_below_fill();
    program_register(ADDR_FRAMES_IN_USE, 4'd2);
    send_reference(16'hC0DE);
    send_reference(16'hC0DE);
    send_reference(16'h0002);
    send_reference(16'hBEEF);
    wait_drained();
  endtask

  // A write to the unused register index must leave the frame limit alone;
  // the readback inside program_register shows it.
  task automatic test_spare_register();
    program_register(ADDR_SPARE_REG, 4'd1);
    send_reference(16'h4321);
    send_reference(16'h3C3C);
    wait_drained();
  endtask

  // The receiver holds off for a long stretch while references keep coming,
  // so the result register fills and the block must stall its input.
  task automatic test_backpressure();
    idle_pct = 0;
    holdoffs_asked <= holdoffs_asked + 1;
    for (int n = 0; n < 20; n++) begin
      send_reference(n[0] ? hot_pages[n % HOT_PAGES] : page_t'($urandom()));
    end
    wait_drained();
    idle_pct = IDLE_PCT;
  endtask

  // Random traffic in phases, each with its own frame limit and working set.
  // Most references come from a small working set so that hits at every list
  // position are common; the rest are arbitrary pages that force faults.
  task automatic test_random_references();
    logic [CFG_W-1:0] limit;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      unique case (phase)
        0: limit = 4'd1;
        1: limit = 4'd8;
        2: limit = 4'd0;
        3: limit = 4'd15;
        default: limit = CFG_W'($urandom_range(15));
      endcase
      program_register(ADDR_FRAMES_IN_USE, limit);
      foreach (hot_pages[i]) hot_pages[i] = page_t'($urandom());
      // One phase runs with neither side idling at all.
      idle_pct = (phase == 3) ? 0 : IDLE_PCT;
      for (int n = 0; n < REFS_PER_PHASE; n++) begin
        if ($urandom_range(99) < 70) begin
          send_reference(hot_pages[$urandom_range(HOT_PAGES - 1)]);
        end else begin
          send_reference(page_t'($urandom()));
        end
      end
      wait_drained();
    end
    idle_pct = IDLE_PCT;
  endtask

  // Receiver: random stalls, plus a hold-off that it counts itself whenever
  // a test asks for one.
  always @(posedge clk) begin
    if (holdoff_left > 0) begin
      holdoff_left <= holdoff_left - 1;
      out_ready <= 1'b0;
    end else if (holdoffs_served != holdoffs_asked) begin
      holdoffs_served <= holdoffs_served + 1;
      holdoff_left <= HOLDOFF_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Result checker: every accepted result beat is matched against the
  // oldest prediction, field by field.
  always @(posedge clk) begin
    lookup_result_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no reference outstanding");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        compare_field("hit", DATA_W'(want.hit), DATA_W'(out_hit));
        compare_field("hit_position", DATA_W'(want.hit_position), DATA_W'(out_hit_position));
        compare_field("evicted_valid", DATA_W'(want.evicted_valid),
                      DATA_W'(out_evicted_valid));
        compare_field("evicted_page", DATA_W'(want.evicted_page), DATA_W'(out_evicted_page));
        compare_field("resident_count", DATA_W'(want.resident_count),
                      DATA_W'(out_resident_count));
      end
    end
  end

  // Watchdog: any accepted beat on either channel or the register port
  // counts as progress; a long stretch without any means the block hung.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid <= 1'b0;
    in_page_number <= '0;
    foreach (hot_pages[i]) hot_pages[i] = page_t'($urandom());
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    // Reset leaves an empty list and the full frame limit.
    resident_list.delete();
    frames_in_use = FRAMES_IN_USE_RESET;
    @(posedge clk);

    // The small limits only show while the list is still short, and the
    // fill count never falls once it reaches eight, so these come first.
    test_limit_zero();
    test_limit_wide();
    test_limit_below_fill();
    test_spare_register();
    test_backpressure();
    test_random_references();

    wait_drained();
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/lpft_pkg.sv
rtl/lpft_ctrl.sv
rtl/lpft_datapath.sv
rtl/lru_page_frame_tracker_core.sv
sim/lru_page_frame_tracker_core_test.sv
